@@ design/mrhs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrhs_pkg
// Shared types and constants for the multi-ring history store.
// ----------------------------------------------------------------------------
`default_nettype none

package mrhs_pkg;

	localparam int MAX_RINGS   = 16;
	localparam int MAX_ENTRIES = 64;
	localparam int ENTRY_BITS  = 64;

	localparam int RING_W  = $clog2(MAX_RINGS);
	localparam int SLOT_W  = $clog2(MAX_ENTRIES);
	localparam int ADDR_W  = RING_W + SLOT_W;
	localparam int DEPTH   = MAX_RINGS * MAX_ENTRIES;

	// register field widths
	localparam int CAP_W   = 7;
	localparam int CNT_W   = 5;
	localparam int PADDR_W = 3;

	// register reset values
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

	// register map index
	typedef enum logic {
		REG_CAPACITY = 1'b0,
		REG_COUNT    = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_ADD    = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_CLEAR  = 3'd2,
		MODE_CLRALL = 3'd3,
		MODE_UPDATE = 3'd4,
		MODE_READ   = 3'd5,
		MODE_COUNT  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_RING = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_OFFSET   = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ design/mrhs_ram.sv @@
// ----------------------------------------------------------------------------
// mrhs_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mrhs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// optional write plus registered read (old data), one access per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ design/multi_ring_history_store_top.sv @@
// Result: a result word appears in the cycle after its command is accepted.
// Throughput: one command per cycle; busy stays low, since pointer updates
// settle at the accept edge and the entry RAM takes one access per cycle.
// Reset: all rings empty, capacity 20, ring count 1. The entry RAM is not
// cleared; entries hold whatever was last written.
// ----------------------------------------------------------------------------
// multi_ring_history_store_top
// Per-ring head/tail/empty pointers in flops, entries in one shared RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_ring_history_store_top import mrhs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            mode,
	input  logic [RING_W-1:0]     ring_index,
	input  logic [SLOT_W-1:0]     entry_offset,
	input  logic [ENTRY_BITS-1:0] entry_data,
	// result channel
	output logic                  done,
	output logic [ENTRY_BITS-1:0] read_data,
	output logic [CAP_W-1:0]      fill_count,
	output logic [1:0]            status,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] head_q  [MAX_RINGS];
	logic [SLOT_W-1:0] tail_q  [MAX_RINGS];
	logic              empty_q [MAX_RINGS];

	logic              done_q;
	logic [CAP_W-1:0]  fill_q;
	status_t           status_q;
	logic              rd_ok_s1;

	logic              cfg_we;
	logic              accept;
	logic [CAP_W-1:0]  cap_use;
	logic [SLOT_W-1:0] cap_m1;
	logic [CNT_W-1:0]  rings_use;
	logic              bad_ring;

	logic [SLOT_W-1:0] h, t, nh, nt, h_back, t_back, slot;
	logic              e, ne, upd, clr_all;
	logic [CAP_W-1:0]  slot_sum;
	logic [CAP_W:0]    fill_wide;
	logic [CAP_W-1:0]  fill_d;
	status_t           st_d;
	logic              ram_we, rd_ok_d;
	logic [SLOT_W-1:0] ram_slot;
	logic [ENTRY_BITS-1:0] ram_rdata;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign cfg_we = psel && penable && pwrite && pready;

	// register read back
	always_comb begin
		if (reg_idx_t'(paddr[2]) == REG_COUNT) begin
			prdata = {{(32-CNT_W){1'b0}}, cnt_q};
		end else begin
			prdata = {{(32-CAP_W){1'b0}}, cap_q};
		end
	end

	// saturated register values
	always_comb begin
		if (cap_q == '0) begin
			cap_use = CAP_W'(1);
		end else if (cap_q > CAP_W'(MAX_ENTRIES)) begin
			cap_use = CAP_W'(MAX_ENTRIES);
		end else begin
			cap_use = cap_q;
		end
		if (cnt_q == '0) begin
			rings_use = CNT_W'(1);
		end else if (cnt_q > CNT_W'(MAX_RINGS)) begin
			rings_use = CNT_W'(MAX_RINGS);
		end else begin
			rings_use = cnt_q;
		end
	end

	assign cap_m1   = SLOT_W'(cap_use - CAP_W'(1));
	assign bad_ring = {{(CNT_W-RING_W){1'b0}}, ring_index} >= rings_use;

	// addressed ring pointers
	assign h      = head_q[ring_index];
	assign t      = tail_q[ring_index];
	assign e      = empty_q[ring_index];
	assign h_back = (h == '0) ? cap_m1 : h - SLOT_W'(1);
	assign t_back = (t == '0) ? cap_m1 : t - SLOT_W'(1);

	// slot at offset from head, wrapped in the ring
	always_comb begin
		slot_sum = {1'b0, h} + {1'b0, entry_offset};
		if (slot_sum >= cap_use) begin
			slot_sum = slot_sum - cap_use;
		end
		slot = slot_sum[SLOT_W-1:0];
	end

	// command decode: next pointers, status, RAM access
	always_comb begin
		nh       = h;
		nt       = t;
		ne       = e;
		upd      = 1'b0;
		clr_all  = 1'b0;
		st_d     = ST_OK;
		ram_we   = 1'b0;
		rd_ok_d  = 1'b0;
		ram_slot = slot;
		if (mode_t'(mode) == MODE_CLRALL) begin
			clr_all = 1'b1;
		end else if (bad_ring) begin
			st_d = ST_BAD_RING;
		end else begin
			case (mode_t'(mode))
				MODE_ADD: begin
					upd    = 1'b1;
					ram_we = 1'b1;
					if (e) begin
						nh = cap_m1;
						nt = cap_m1;
						ne = 1'b0;
					end else begin
						nh = h_back;
						if (h_back == t) begin
							nt = t_back;
						end
					end
					ram_slot = nh;
				end
				MODE_REMOVE: begin
					if (e) begin
						st_d = ST_EMPTY;
					end else if (t == h) begin
						upd = 1'b1;
						nh  = '0;
						nt  = '0;
						ne  = 1'b1;
					end else begin
						upd = 1'b1;
						nt  = t_back;
					end
				end
				MODE_CLEAR: begin
					upd = 1'b1;
					nh  = '0;
					nt  = '0;
					ne  = 1'b1;
				end
				MODE_UPDATE, MODE_READ: begin
					if (e) begin
						st_d = ST_EMPTY;
					end else if ({1'b0, entry_offset} >= cap_use) begin
						st_d = ST_OFFSET;
					end else if (mode_t'(mode) == MODE_UPDATE) begin
						ram_we = 1'b1;
					end else begin
						rd_ok_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// fill of the addressed ring after the command
	always_comb begin
		if (ne) begin
			fill_wide = '0;
		end else if (nt < nh) begin
			fill_wide = {2'b0, nt} + {1'b0, cap_use} + (CAP_W+1)'(1) - {2'b0, nh};
		end else begin
			fill_wide = {2'b0, nt} - {2'b0, nh} + (CAP_W+1)'(1);
		end
		if (clr_all || st_d == ST_BAD_RING) begin
			fill_d = '0;
		end else begin
			fill_d = fill_wide[CAP_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			cnt_q <= CNT_RESET;
		end else if (cfg_we) begin
			if (reg_idx_t'(paddr[2]) == REG_COUNT) begin
				cnt_q <= pwdata[CNT_W-1:0];
			end else begin
				cap_q <= pwdata[CAP_W-1:0];
			end
		end
	end

	// ring pointer table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RINGS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				empty_q[i] <= 1'b1;
			end
		end else if (cfg_we || (accept && clr_all)) begin
			for (int i = 0; i < MAX_RINGS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				empty_q[i] <= 1'b1;
			end
		end else if (accept && upd) begin
			head_q[ring_index]  <= nh;
			tail_q[ring_index]  <= nt;
			empty_q[ring_index] <= ne;
		end
	end

	// entry store
	mrhs_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && ram_we),
		.addr ({ring_index, ram_slot}),
		.wdata(entry_data),
		.rdata(ram_rdata)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			rd_ok_s1 <= 1'b0;
		end else begin
			done_q   <= accept;
			rd_ok_s1 <= accept && rd_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_q   <= fill_d;
			status_q <= st_d;
		end
	end

	assign done       = done_q;
	assign fill_count = fill_q;
	assign status     = status_q;
	assign read_data  = rd_ok_s1 ? ram_rdata : '0;

endmodule

`default_nettype wire

@@ design/mrhs_checker.sv @@
// ----------------------------------------------------------------------------
// mrhs_checker
// Port-level checks on result timing and result word consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module mrhs_checker import mrhs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [ENTRY_BITS-1:0] read_data,
	input logic [CAP_W-1:0]      fill_count,
	input logic [1:0]            status
);

	// every accepted command gives a word on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("result word missing one cycle after accept");

	// no word without a command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result word without an accepted command");

	// failed commands never return data
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> read_data == '0)
		else $error("read data on a failed command");

	// bad ring or empty ring reports no fill
	a_fail_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_BAD_RING || status == ST_EMPTY) |-> fill_count == '0)
		else $error("nonzero fill on bad or empty ring");

	// fill never exceeds the maximum ring capacity
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_count <= CAP_W'(MAX_ENTRIES))
		else $error("fill count beyond maximum capacity");

endmodule

bind multi_ring_history_store_top mrhs_checker u_mrhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.read_data (read_data),
	.fill_count(fill_count),
	.status    (status)
);

`default_nettype wire
